### src/lcdns_pkg.sv
package lcdns_pkg;

   localparam int COLUMNS_DEFAULT = 16;
   localparam int INIT_LEN = 23;
   localparam int QUEUE_DEPTH = 2;
   localparam int IDX_W = $clog2(INIT_LEN);

   typedef enum logic [3:0] {
      KIND_INIT     = 4'd0,
      KIND_CLEAR    = 4'd1,
      KIND_HOME     = 4'd2,
      KIND_RIGHT    = 4'd3,
      KIND_LEFT     = 4'd4,
      KIND_ERASE    = 4'd5,
      KIND_UP       = 4'd6,
      KIND_DOWN     = 4'd7,
      KIND_SET_POS  = 4'd8,
      KIND_PUT_CHAR = 4'd9
   } kind_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] char_code;
      logic [1:0] target_line;
      logic [4:0] target_col;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       last;
      logic [1:0] line_now;
      logic [4:0] col_now;
   } rsp_type;

   // One classified command: either the power-up sequence or one or two bytes.
   typedef struct packed {
      logic       init_seq;
      logic       two_bytes;
      logic       rs0;
      logic [7:0] byte0;
      logic       rs1;
      logic [7:0] byte1;
      logic [1:0] line_now;
      logic [4:0] col_now;
   } entry_type;

   // Power-up sequence: three rounds of function set, display on, entry mode,
   // then a clear.
   function automatic logic [3:0] init_nibble(input logic [IDX_W-1:0] idx);
      logic [3:0] nib;
      case (idx)
         5'd0, 5'd1, 5'd7, 5'd8, 5'd14, 5'd15: nib = 4'h2;
         5'd2, 5'd9, 5'd16:                    nib = 4'h8;
         5'd4, 5'd11, 5'd18:                   nib = 4'hE;
         5'd6, 5'd13, 5'd20:                   nib = 4'h6;
         5'd22:                                nib = 4'h1;
         default:                              nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

### src/lcdns_front.sv
module lcdns_front #(
   parameter int COLUMNS = lcdns_pkg::COLUMNS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  lcdns_pkg::req_type    req_data,
   output logic                  push,
   output lcdns_pkg::entry_type  entry
);
   import lcdns_pkg::*;

   localparam int CW = $clog2(COLUMNS + 2);
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME = 8'h02;
   localparam logic [7:0] CMD_RIGHT = 8'h14;
   localparam logic [7:0] CMD_LEFT = 8'h10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CW-1:0] COL_ONE = CW'(1);
   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS);
   localparam logic [CW-1:0] COL_PAST = CW'(COLUMNS + 1);

   logic [1:0]    line_ff, line_in;
   logic [CW-1:0] col_ff, col_in;

   logic          use_wrap;
   logic [1:0]    wrap_line;
   logic [CW-1:0] wrap_col;
   logic [CW+4:0] tc_wide;
   logic [CW+4:0] tc_clamped;
   logic [CW+4:0] col_wide;
   logic          valid_kind;

   // Set-address command for a position; line is 1 or 2, column from 1.
   function automatic logic [7:0] pos_addr(input logic line2, input logic [CW-1:0] col);
      logic [CW+5:0] offset;
      offset = {6'd0, col - COL_ONE};
      return {1'b1, line2, offset[5:0]};
   endfunction

   always_comb begin
      entry = '0;
      valid_kind = 1'b1;
      use_wrap = 1'b0;
      wrap_line = line_ff;
      wrap_col = col_ff;
      line_in = line_ff;
      col_in = col_ff;
      tc_wide = {CW'(0), req_data.target_col};
      tc_clamped = tc_wide;
      if (tc_wide == '0) begin
         tc_clamped = (CW+5)'(1);
      end else if (tc_wide > (CW+5)'(COLUMNS)) begin
         tc_clamped = (CW+5)'(COLUMNS);
      end
      unique case (req_data.kind)
         KIND_INIT: begin
            entry.init_seq = 1'b1;
            line_in = 2'd1;
            col_in = COL_ONE;
         end
         KIND_CLEAR: begin
            entry.byte0 = CMD_CLEAR;
            line_in = 2'd1;
            col_in = COL_ONE;
         end
         KIND_HOME: begin
            entry.byte0 = CMD_HOME;
            line_in = 2'd1;
            col_in = COL_ONE;
         end
         KIND_RIGHT: begin
            entry.byte0 = CMD_RIGHT;
            use_wrap = 1'b1;
            wrap_col = col_ff + COL_ONE;
         end
         KIND_LEFT: begin
            entry.byte0 = CMD_LEFT;
            use_wrap = 1'b1;
            wrap_col = col_ff - COL_ONE;
         end
         KIND_ERASE: begin
            entry.rs0 = 1'b1;
            entry.byte0 = CHAR_SPACE;
            entry.two_bytes = 1'b1;
            entry.byte1 = pos_addr(line_ff == 2'd2, col_ff);
         end
         KIND_UP: begin
            entry.byte0 = pos_addr(1'b0, col_ff);
            line_in = 2'd1;
         end
         KIND_DOWN: begin
            entry.byte0 = pos_addr(1'b1, col_ff);
            line_in = 2'd2;
         end
         KIND_SET_POS: begin
            line_in = (req_data.target_line >= 2'd2) ? 2'd2 : 2'd1;
            col_in = tc_clamped[CW-1:0];
            entry.byte0 = pos_addr(req_data.target_line >= 2'd2, tc_clamped[CW-1:0]);
         end
         KIND_PUT_CHAR: begin
            use_wrap = 1'b1;
            wrap_col = col_ff + COL_ONE;
            if (req_data.char_code == CHAR_NEWLINE) begin
               entry.byte0 = pos_addr(1'b1, col_ff);
               wrap_line = 2'd2;
            end else begin
               entry.rs0 = 1'b1;
               entry.byte0 = req_data.char_code;
            end
         end
         default: begin
            valid_kind = 1'b0;
         end
      endcase

      // Wrapping at either end of a line adds one position or home command.
      if (use_wrap) begin
         line_in = wrap_line;
         col_in = wrap_col;
         if (wrap_col == COL_PAST) begin
            entry.two_bytes = 1'b1;
            if (wrap_line == 2'd1) begin
               entry.byte1 = pos_addr(1'b1, COL_ONE);
               line_in = 2'd2;
            end else begin
               entry.byte1 = CMD_HOME;
               line_in = 2'd1;
            end
            col_in = COL_ONE;
         end else if (wrap_col == '0) begin
            entry.two_bytes = 1'b1;
            entry.byte1 = pos_addr(wrap_line == 2'd1, COL_LAST);
            line_in = (wrap_line == 2'd1) ? 2'd2 : 2'd1;
            col_in = COL_LAST;
         end
      end

      col_wide = {5'd0, col_in};
      entry.line_now = line_in;
      entry.col_now = col_wide[4:0];
      push = accept && valid_kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= 2'd1;
         col_ff <= COL_ONE;
      end else if (accept && valid_kind) begin
         line_ff <= line_in;
         col_ff <= col_in;
      end
   end

endmodule

### src/lcdns_queue.sv
module lcdns_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lcdns_pkg::entry_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output lcdns_pkg::entry_type  head
);
   import lcdns_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/lcdns_back.sv
module lcdns_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  entry_valid,
   input  lcdns_pkg::entry_type  entry,
   output logic                  entry_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output lcdns_pkg::rsp_type    rsp_data
);
   import lcdns_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;
   logic             emit;
   logic [IDX_W-1:0] last_idx;
   logic             is_last;
   logic [7:0]       cur_byte;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

   // The output register takes a new nibble when an entry waits and the register is free or being drained.
   assign emit = entry_valid && (!out_valid_ff || rsp_pop);

   always_comb begin
      if (entry.init_seq) begin
         last_idx = IDX_W'(INIT_LEN - 1);
      end else if (entry.two_bytes) begin
         last_idx = IDX_W'(3);
      end else begin
         last_idx = IDX_W'(1);
      end
      is_last = (idx_ff == last_idx);
      cur_byte = idx_ff[1] ? entry.byte1 : entry.byte0;

      out_in = out_ff;
      out_in.last = is_last;
      out_in.line_now = entry.line_now;
      out_in.col_now = entry.col_now;
      if (entry.init_seq) begin
         out_in.reg_select = 1'b0;
         out_in.nibble = init_nibble(idx_ff);
      end else begin
         out_in.reg_select = idx_ff[1] ? entry.rs1 : entry.rs0;
         out_in.nibble = idx_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
      end

      idx_in = idx_ff;
      entry_pop = 1'b0;
      if (emit) begin
         if (is_last) begin
            idx_in = '0;
            entry_pop = 1'b1;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
      end
   end

endmodule

### src/char_lcd_nibble_sequencer.sv
// Turns character LCD commands into the nibble writes of a 4-bit bus, one
// result per enable pulse, high nibble first, each with its register-select
// level and the cursor position that holds once the command is done. A command
// is taken while the two-entry command queue has room; the output side then
// produces one nibble per cycle while its result register is empty or popped,
// so a command occupies it for two nibbles (one byte), four nibbles (a byte plus
// a position or home command after erase or a wrap) or 23 nibbles (init).
// Unknown command codes are taken and produce nothing.
module char_lcd_nibble_sequencer #(
   parameter int COLUMNS = lcdns_pkg::COLUMNS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  lcdns_pkg::req_type req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output lcdns_pkg::rsp_type rsp_data
);
   import lcdns_pkg::*;

   logic      accept;
   logic      q_push;
   entry_type q_push_data;
   logic      q_full;
   logic      q_pop;
   logic      q_valid;
   entry_type q_head;

   assign req_full = q_full;
   assign accept = req_push && !q_full;

   lcdns_front #(
      .COLUMNS(COLUMNS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_data(req_data),
      .push(q_push),
      .entry(q_push_data)
   );

   lcdns_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .full(q_full),
      .pop(q_pop),
      .valid(q_valid),
      .head(q_head)
   );

   lcdns_back u_back (
      .clock(clock),
      .reset(reset),
      .entry_valid(q_valid),
      .entry(q_head),
      .entry_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

endmodule

### tb/tb_char_lcd_nibble_sequencer.sv
module tb_char_lcd_nibble_sequencer;
   import lcdns_pkg::*;

   localparam int COLS = COLUMNS_DEFAULT;
   localparam int ITEM_TARGET = 360;
   localparam int HOLD_AT = 80;
   localparam int LONG_HOLD = 120;
   localparam int DRAIN_AT = 160;
   localparam int CALM_AT = ITEM_TARGET - 50;
   localparam int DRAIN_CYCLES = 2 * INIT_LEN;
   localparam int CYCLE_LIMIT = 300000;

   localparam logic [3:0] KIND_UNUSED_LO = 4'd10;
   localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

   localparam logic [7:0] LCD_CLEAR_CMD = 8'h01;
   localparam logic [7:0] LCD_HOME_CMD = 8'h02;
   localparam logic [7:0] LCD_SHIFT_RIGHT = 8'h14;
   localparam logic [7:0] LCD_SHIFT_LEFT = 8'h10;
   localparam logic [7:0] LCD_SPACE = 8'h20;
   localparam logic [7:0] LCD_NEWLINE = 8'h0A;
   localparam int DDRAM_BASE = 128;
   localparam int LINE_STRIDE = 64;
   localparam logic [3:0] INIT_ROUND [7] = '{4'h2, 4'h2, 4'h8, 4'h0, 4'hE, 4'h0, 4'h6};

   localparam rsp_type NO_RSP = '0;

   // A directed command; where typed is set, its transfers are given here
   // instead of being worked out by the cursor tracker.
   typedef struct packed {
      req_type    cmd;
      logic       typed;
      logic [1:0] typed_n;
      rsp_type    first;
      rsp_type    second;
   } drill_row_type;

   localparam int DRILL_N = 23;
   localparam drill_row_type DRILL [DRILL_N] = '{
      '{'{KIND_CLEAR, 8'h00, 2'd1, 5'd1}, 1'b1, 2'd2,
        '{1'b0, 4'h0, 1'b0, 2'd1, 5'd1}, '{1'b0, 4'h1, 1'b1, 2'd1, 5'd1}},
      '{'{KIND_INIT, 8'h00, 2'd0, 5'd0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_HOME, 8'h00, 2'd1, 5'd1}, 1'b1, 2'd2,
        '{1'b0, 4'h0, 1'b0, 2'd1, 5'd1}, '{1'b0, 4'h2, 1'b1, 2'd1, 5'd1}},
      '{'{KIND_UNUSED_LO, 8'h00, 2'd0, 5'd0}, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_UNUSED_HI, 8'hFF, 2'd3, 5'd31}, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_RIGHT, 8'h00, 2'd1, 5'd1}, 1'b1, 2'd2,
        '{1'b0, 4'h1, 1'b0, 2'd1, 5'd2}, '{1'b0, 4'h4, 1'b1, 2'd1, 5'd2}},
      '{'{KIND_LEFT, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_LEFT, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_RIGHT, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_PUT_CHAR, 8'hFF, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_PUT_CHAR, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_PUT_CHAR, LCD_NEWLINE, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_ERASE, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_UP, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_DOWN, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_SET_POS, 8'h00, 2'd0, 5'd0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_SET_POS, 8'h00, 2'd3, 5'd31}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_SET_POS, 8'h00, 2'd1, 5'd16}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_PUT_CHAR, 8'h41, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_SET_POS, 8'h00, 2'd2, 5'd16}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_PUT_CHAR, LCD_NEWLINE, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_SET_POS, 8'h00, 2'd2, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{KIND_LEFT, 8'h00, 2'd1, 5'd1}, 1'b0, 2'd0, NO_RSP, NO_RSP}
   };

   logic    clock;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // Cursor as the tracker sees it; kept wide so that 0 and COLS+1 can occur.
   int      cur_line = 1;
   int      cur_col = 1;
   rsp_type cmd_nibbles[$];
   rsp_type expected_nibbles[$];

   int      error_count = 0;
   int      command_count = 0;
   int      cycle_count = 0;
   bit      calm = 1'b0;
   bit      send_steady = 1'b0;
   bit      drained = 1'b0;
   bit      pop_steady = 1'b0;
   bit      held = 1'b0;
   int      stall_left = 0;

   char_lcd_nibble_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_char_lcd_nibble_sequencer: errors");
         $finish;
      end
   end

   function automatic void put_byte(input logic rs, input logic [7:0] value);
      cmd_nibbles.push_back('{rs, value[7:4], 1'b0, 2'd0, 5'd0});
      cmd_nibbles.push_back('{rs, value[3:0], 1'b0, 2'd0, 5'd0});
   endfunction

   function automatic void move_cursor(input int line, input int col);
      put_byte(1'b0, 8'(DDRAM_BASE + (line - 1) * LINE_STRIDE + col - 1));
      cur_line = line;
      cur_col = col;
   endfunction

   function automatic void send_home();
      put_byte(1'b0, LCD_HOME_CMD);
      cur_line = 1;
      cur_col = 1;
   endfunction

   function automatic void wrap_cursor();
      if (cur_col == COLS + 1) begin
         if (cur_line == 1) move_cursor(2, 1);
         else send_home();
      end else if (cur_col == 0) begin
         move_cursor((cur_line == 1) ? 2 : 1, COLS);
      end
   endfunction

   // Works out the nibble transfers of one command and moves the cursor.
   function automatic void track_command(input req_type cmd);
      int line_sel;
      int col_sel;
      cmd_nibbles.delete();
      case (cmd.kind)
         KIND_INIT: begin
            for (int r = 0; r < 3; r++)
               foreach (INIT_ROUND[i])
                  cmd_nibbles.push_back('{1'b0, INIT_ROUND[i], 1'b0, 2'd0, 5'd0});
            put_byte(1'b0, LCD_CLEAR_CMD);
            cur_line = 1;
            cur_col = 1;
         end
         KIND_CLEAR: begin
            put_byte(1'b0, LCD_CLEAR_CMD);
            cur_line = 1;
            cur_col = 1;
         end
         KIND_HOME: send_home();
         KIND_RIGHT: begin
            put_byte(1'b0, LCD_SHIFT_RIGHT);
            cur_col++;
            wrap_cursor();
         end
         KIND_LEFT: begin
            put_byte(1'b0, LCD_SHIFT_LEFT);
            cur_col--;
            wrap_cursor();
         end
         KIND_ERASE: begin
            put_byte(1'b1, LCD_SPACE);
            move_cursor(cur_line, cur_col);
         end
         KIND_UP: move_cursor(1, cur_col);
         KIND_DOWN: move_cursor(2, cur_col);
         KIND_SET_POS: begin
            line_sel = (cmd.target_line == 2'd0) ? 1 : (cmd.target_line > 2'd2) ? 2 :
                       int'(cmd.target_line);
            col_sel = (cmd.target_col == 5'd0) ? 1 : (int'(cmd.target_col) > COLS) ? COLS :
                      int'(cmd.target_col);
            move_cursor(line_sel, col_sel);
         end
         KIND_PUT_CHAR: begin
            if (cmd.char_code == LCD_NEWLINE) move_cursor(2, cur_col);
            else put_byte(1'b1, cmd.char_code);
            cur_col++;
            wrap_cursor();
         end
         default: ;
      endcase
      foreach (cmd_nibbles[k]) begin
         cmd_nibbles[k].last = (k == cmd_nibbles.size() - 1);
         cmd_nibbles[k].line_now = 2'(cur_line);
         cmd_nibbles[k].col_now = 5'(cur_col);
      end
   endfunction

   function automatic req_type random_command();
      req_type cmd;
      int      pick;
      pick = $urandom_range(0, 99);
      cmd.char_code = ($urandom_range(0, 7) == 0) ? LCD_NEWLINE : 8'($urandom_range(0, 255));
      cmd.target_line = 2'($urandom_range(0, 3));
      cmd.target_col = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                       5'($urandom_range(1, COLS));
      if (pick < 2) cmd.kind = KIND_INIT;
      else if (pick < 6)
         cmd.kind = 4'($urandom_range(int'(KIND_UNUSED_LO), int'(KIND_UNUSED_HI)));
      else if (pick < 10) cmd.kind = KIND_CLEAR;
      else if (pick < 14) cmd.kind = KIND_HOME;
      else if (pick < 26) cmd.kind = KIND_RIGHT;
      else if (pick < 38) cmd.kind = KIND_LEFT;
      else if (pick < 46) cmd.kind = KIND_ERASE;
      else if (pick < 52) cmd.kind = KIND_UP;
      else if (pick < 58) cmd.kind = KIND_DOWN;
      else if (pick < 72) cmd.kind = KIND_SET_POS;
      else cmd.kind = KIND_PUT_CHAR;
      return cmd;
   endfunction

   // Holds the command on the input until it is taken, then books its
   // transfers and maybe idles for a few cycles.
   task automatic offer_command(input drill_row_type row);
      req_push <= 1'b1;
      req_data <= row.cmd;
      do @(posedge clock); while (req_full);
      track_command(row.cmd);
      if (row.typed) begin
         cmd_nibbles.delete();
         if (row.typed_n > 2'd0) cmd_nibbles.push_back(row.first);
         if (row.typed_n > 2'd1) cmd_nibbles.push_back(row.second);
      end
      foreach (cmd_nibbles[k]) expected_nibbles.push_back(cmd_nibbles[k]);
      if (row.cmd.kind <= KIND_PUT_CHAR) command_count++;
      if ($urandom_range(0, 24) == 0) send_steady = !send_steady;
      if (!calm && !send_steady && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic check_nibble(input rsp_type got);
      rsp_type want;
      if (expected_nibbles.size() == 0) begin
         $error("unexpected transfer: nibble %0h with nothing expected", got.nibble);
         error_count++;
         return;
      end
      want = expected_nibbles.pop_front();
      if (got.reg_select !== want.reg_select) begin
         $error("reg_select: expected %0d, got %0d", want.reg_select, got.reg_select);
         error_count++;
      end
      if (got.nibble !== want.nibble) begin
         $error("nibble: expected %0h, got %0h", want.nibble, got.nibble);
         error_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         error_count++;
      end
      if (got.line_now !== want.line_now) begin
         $error("line_now: expected %0d, got %0d", want.line_now, got.line_now);
         error_count++;
      end
      if (got.col_now !== want.col_now) begin
         $error("col_now: expected %0d, got %0d", want.col_now, got.col_now);
         error_count++;
      end
   endtask

   // Result side: checks each transfer and stalls in short bursts, plus one
   // long hold-off that lets the command queue fill up.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_pop && !rsp_empty) check_nibble(rsp_data);
            if ($urandom_range(0, 49) == 0) pop_steady = !pop_steady;
            if (!held && command_count >= HOLD_AT) begin
               held = 1'b1;
               stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !calm && !pop_steady &&
                         $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= 1'b1;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DRILL[i]) offer_command(DRILL[i]);
      while (command_count < ITEM_TARGET) begin
         offer_command('{random_command(), 1'b0, 2'd0, NO_RSP, NO_RSP});
         if (command_count >= CALM_AT) calm = 1'b1;
         if (!drained && command_count >= DRAIN_AT) begin
            drained = 1'b1;
            req_push <= 1'b0;
            while (expected_nibbles.size() != 0) @(posedge clock);
            @(posedge clock);
         end
      end
      req_push <= 1'b0;
      while (expected_nibbles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_char_lcd_nibble_sequencer: clean");
      end else begin
         $display("tb_char_lcd_nibble_sequencer: errors");
      end
      $finish;
   end

endmodule

### files.f
src/lcdns_pkg.sv
src/lcdns_front.sv
src/lcdns_queue.sv
src/lcdns_back.sv
src/char_lcd_nibble_sequencer.sv
tb/tb_char_lcd_nibble_sequencer.sv
